FILE: rtl/core/fud_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fud_pkg;

   localparam logic [7:0] CharAmp     = 8'h26;  // '&'
   localparam logic [7:0] CharPercent = 8'h25;  // '%'
   localparam logic [7:0] CharPlus    = 8'h2B;  // '+'
   localparam logic [7:0] CharEquals  = 8'h3D;  // '='
   localparam logic [7:0] CharSpace   = 8'h20;
   localparam logic [7:0] CharUpperA  = 8'h41;
   localparam logic [7:0] CharLowerA  = 8'h61;
   localparam logic [7:0] CharZero    = 8'h30;

   // Result queue: one input byte can push two words, so the queue must hold
   // at least two entries beyond those still being drained.
   localparam int QueueDepth = 4;
   localparam int QueueAw    = $clog2(QueueDepth);

   typedef enum logic [1:0] {
      KIND_KEY     = 2'd0,
      KIND_VALUE   = 2'd1,
      KIND_COMMIT  = 2'd2,
      KIND_ABANDON = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_FIRST  = 2'd1,
      PH_SECOND = 2'd2
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } result_type;

   // Words produced by one input byte, first in slot zero.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   // Bit 4 set means the byte is not a hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] d;
      d = 5'h10;
      if (c >= CharZero && c <= 8'h39) begin
         d = {1'b0, 4'(c - CharZero)};
      end else if (c >= CharUpperA && c <= 8'h46) begin
         d = {1'b0, 4'(c - (CharUpperA - 8'd10))};
      end else if (c >= CharLowerA && c <= 8'h66) begin
         d = {1'b0, 4'(c - (CharLowerA - 8'd10))};
      end
      return d;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fud_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module fud_decode
   import fud_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] raw_char,
   input  wire logic       final_char,
   output push_type        push
);

   phase_type  phase_ff, phase_in;
   logic [3:0] hval_ff, hval_in;
   logic       hvalid_ff, hvalid_in;
   logic       inval_ff, inval_in;
   logic       keyhas_ff, keyhas_in;

   always_comb begin
      logic [4:0] d;
      logic [7:0] v;
      logic       has_byte;
      logic [7:0] b;
      result_type r0, r1;
      logic [1:0] n;

      phase_in  = phase_ff;
      hval_in   = hval_ff;
      hvalid_in = hvalid_ff;
      inval_in  = inval_ff;
      keyhas_in = keyhas_ff;
      has_byte  = 1'b0;
      b         = '0;
      r0        = '{kind: KIND_KEY, data: '0, last: 1'b0};
      r1        = '{kind: KIND_KEY, data: '0, last: 1'b0};
      n         = '0;
      d         = hex_digit(raw_char);
      v         = '0;

      case (phase_ff)
         PH_FIRST: begin
            hvalid_in = ~d[4];
            hval_in   = d[3:0];
            phase_in  = PH_SECOND;
            if (final_char && !d[4] && d[3:0] != 4'd0) begin
               b        = {4'd0, d[3:0]};
               has_byte = 1'b1;
            end
         end
         PH_SECOND: begin
            phase_in = PH_IDLE;
            if (hvalid_ff) begin
               v = d[4] ? {4'd0, hval_ff} : {hval_ff, d[3:0]};
               if (v != 8'd0) begin
                  b        = v;
                  has_byte = 1'b1;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (raw_char == CharPercent) begin
               phase_in = PH_FIRST;
            end else if (raw_char == CharAmp) begin
               if (inval_ff) begin
                  r0        = '{kind: KIND_COMMIT, data: '0, last: 1'b0};
                  n         = 2'd1;
                  inval_in  = 1'b0;
                  keyhas_in = 1'b0;
               end
            end else if (raw_char == CharPlus) begin
               b        = CharSpace;
               has_byte = 1'b1;
            end else begin
               b        = raw_char;
               has_byte = 1'b1;
            end
         end
      endcase

      // A decoded byte never follows a commit word within the same input.
      if (has_byte) begin
         if (!inval_in && b == CharEquals) begin
            inval_in = 1'b1;
         end else if (inval_in) begin
            r0 = '{kind: KIND_VALUE, data: b, last: 1'b0};
            n  = 2'd1;
         end else begin
            r0        = '{kind: KIND_KEY, data: b, last: 1'b0};
            n         = 2'd1;
            keyhas_in = 1'b1;
         end
      end

      if (final_char) begin
         if (inval_in || keyhas_in) begin
            if (n == 2'd0) begin
               r0 = '{kind: inval_in ? KIND_COMMIT : KIND_ABANDON, data: '0, last: 1'b0};
            end else begin
               r1 = '{kind: inval_in ? KIND_COMMIT : KIND_ABANDON, data: '0, last: 1'b0};
            end
            n = n + 2'd1;
         end
         phase_in  = PH_IDLE;
         hval_in   = '0;
         hvalid_in = 1'b0;
         inval_in  = 1'b0;
         keyhas_in = 1'b0;
      end

      if (n == 2'd1) begin
         r0.last = 1'b1;
      end else if (n == 2'd2) begin
         r1.last = 1'b1;
      end

      push.count  = n;
      push.first  = r0;
      push.second = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         hval_ff   <= '0;
         hvalid_ff <= 1'b0;
         inval_ff  <= 1'b0;
         keyhas_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         hval_ff   <= hval_in;
         hvalid_ff <= hvalid_in;
         inval_ff  <= inval_in;
         keyhas_ff <= keyhas_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/fud_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fud_queue
   import fud_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic accept,
   input  wire push_type push,
   output logic      room,
   output logic      out_valid,
   input  wire logic out_ready,
   output result_type out_word
);

   result_type              entry_ff [QueueDepth];
   logic [QueueAw-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QueueAw-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QueueAw:0]        count_ff, count_in;
   logic                    pop;
   logic [1:0]              npush;
   logic [QueueAw-1:0]      wr_next;

   assign pop       = out_valid && out_ready;
   assign npush     = accept ? push.count : 2'd0;
   assign wr_next   = wr_ptr_ff + QueueAw'(1);
   assign out_valid = count_ff != '0;
   assign out_word  = entry_ff[rd_ptr_ff];
   // A byte is taken only while two entries are free for it.
   assign room      = count_ff <= (QueueAw + 1)'(QueueDepth - 2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueueAw'(npush);
      rd_ptr_in = rd_ptr_ff + QueueAw'(pop);
      count_in  = count_ff + (QueueAw + 1)'(npush) - (QueueAw + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (npush != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (npush == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/form_urlencoded_pair_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Decodes a form-urlencoded query string one raw byte per word: '+' becomes a
// space, %XY escapes become one byte, and each decoded byte comes out tagged as
// a key or value byte; a raw '&' in a value and the last byte of the string
// (req_tlast) add a commit or abandon word. A byte is taken in every cycle while
// it produces at most one word and rsp_tready is high; a two-word byte can hold
// off later bytes, since the four-entry result queue drains one word per cycle
// and the input is held off whenever fewer than two entries are free.
module form_urlencoded_pair_decoder
   import fud_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] raw_char
   input  wire logic       req_tlast,   // final_char
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic [1:0]      rsp_tuser,   // [1:0] result_kind
   output logic            rsp_tlast    // run_last
);

   logic       accept;
   logic       room;
   push_type   push;
   result_type out_word;

   assign req_tready = room;
   assign accept     = req_tvalid && room;

   fud_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .raw_char   (req_tdata),
      .final_char (req_tlast),
      .push       (push)
   );

   fud_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (out_word)
   );

   assign rsp_tdata = out_word.data;
   assign rsp_tuser = out_word.kind;
   assign rsp_tlast = out_word.last;

endmodule

`default_nettype wire
